[hdl/hfi_pkg.sv]
// ----------------------------------------------------------------------------
// hfi_pkg
// Shared types, sizes and rounding for the half-band interpolator by two.
// ----------------------------------------------------------------------------
package hfi_pkg;

    // filter geometry
    localparam int EVEN_TAPS    = 6;
    localparam int SAMPLE_WIDTH = 16;
    localparam int ODD_DELAY    = (EVEN_TAPS / 2) - 1;

    // coefficient format is fixed q1.15
    localparam int COEF_WIDTH = 16;
    localparam int FRAC_BITS  = 15;

    // full precision product and sum
    localparam int PROD_W    = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int ACC_W     = PROD_W + $clog2(EVEN_TAPS);
    localparam int TAP_IDX_W = $clog2(EVEN_TAPS);

    // configuration register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_COEF = 3'd6;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [ACC_W-1:0]        acc_t;

    // control for the row of cells
    typedef struct packed {
        logic shift;   // push a new sample into the history
        logic rotate;  // circulate sample and tap one place toward cell 0
    } cell_ctrl_t;

    // round to nearest (ties up), then saturate to the sample width
    function automatic sample_t round_sat(input acc_t acc);
        localparam logic signed [ACC_W:0] RND =
            {{(ACC_W + 1 - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
        localparam logic signed [ACC_W:0] SMAX =
            {{(ACC_W + 2 - SAMPLE_WIDTH){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
        localparam logic signed [ACC_W:0] SMIN = ~SMAX;
        logic signed [ACC_W:0] v;
        logic signed [ACC_W:0] q;
        sample_t res;
        v = {acc[ACC_W-1], acc} + RND;
        q = v >>> FRAC_BITS;
        if (q > SMAX)
        begin
            res = SMAX[SAMPLE_WIDTH-1:0];
        end
        else if (q < SMIN)
        begin
            res = SMIN[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            res = q[SAMPLE_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

[hdl/hfi_if.sv]
// ----------------------------------------------------------------------------
// hfi_if
// Valid/ready channels of the interpolator: sample in, pair out, config.
// ----------------------------------------------------------------------------
interface hfi_in_if
    import hfi_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface hfi_out_if
    import hfi_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t even_out;
    sample_t odd_out;

    modport source (output valid, output even_out, output odd_out, input ready);
    modport sink   (input valid, input even_out, input odd_out, output ready);
endinterface

interface hfi_cfg_if
    import hfi_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    coef_t                data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/hfi_cell.sv]
// ----------------------------------------------------------------------------
// hfi_cell
// One tap of the row: holds one history sample and its even-branch tap.
// ----------------------------------------------------------------------------
module hfi_cell
    import hfi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       cfg_we,
    input  coef_t      cfg_data,
    input  sample_t    shift_sample,
    input  sample_t    rot_sample,
    input  coef_t      rot_coef,
    output sample_t    sample,
    output coef_t      coef
);

    sample_t sample_reg;
    sample_t sample_next;
    coef_t   coef_reg;
    coef_t   coef_next;

    // next contents: shift in history, rotate for the mac pass, or load a tap
    always_comb
    begin
        sample_next = sample_reg;
        coef_next   = coef_reg;
        if (ctrl.shift)
        begin
            sample_next = shift_sample;
        end
        else if (ctrl.rotate)
        begin
            sample_next = rot_sample;
            coef_next   = rot_coef;
        end
        if (cfg_we)
        begin
            coef_next = cfg_data;
        end
    end

    // storage, history cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            coef_reg   <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
            coef_reg   <= coef_next;
        end
    end

    assign sample = sample_reg;
    assign coef   = coef_reg;

endmodule

[hdl/hfi_mac.sv]
// ----------------------------------------------------------------------------
// hfi_mac
// Multiply-accumulate fed by the head of the cell row, product registered.
// ----------------------------------------------------------------------------
module hfi_mac
    import hfi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    clear,
    input  logic    mul_en,
    input  coef_t   coef,
    input  sample_t sample,
    output acc_t    acc
);

    prod_t prod_reg;
    prod_t prod_next;
    logic  prod_vld_reg;
    logic  prod_vld_next;
    acc_t  acc_reg;
    acc_t  acc_next;

    // product stage then accumulate stage
    always_comb
    begin
        prod_next     = mul_en ? coef * sample : prod_reg;
        prod_vld_next = mul_en && !clear;
        acc_next      = acc_reg;
        if (clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= prod_vld_next;
            acc_reg      <= acc_next;
        end
    end

    // product register carries no control meaning
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign acc = acc_reg;

endmodule

[hdl/halfband_interpolator_by_two.sv]
// ----------------------------------------------------------------------------
// halfband_interpolator_by_two
// Polyphase half-band interpolator by two over a row of tap cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one input sample per beat (sample_in, q1.15).
//   out_ch : one beat per input, even_out then odd_out in time order.
//   cfg    : index 0..5 writes even taps 0..5, index 6 the centre tap;
//            other indexes are dropped. cfg.ready is always high; write
//            only while no sample is in flight.
// Sequence:
//   an input beat starts one rotation of the cell row, which feeds the
//   single multiply-accumulate one tap per cycle (states RUN, DRAIN, DONE);
//   the pair is then registered onto out_ch. No new sample is taken until
//   that result has been loaded into the output register.
// Reset:
//   history and taps clear to zero, out_ch.valid drops, in_ch.ready rises.
// Stall:
//   a result waits in the output register while the next sample is taken
//   and processed; that sample's result is held back until the receiver
//   takes the waiting beat, and no new sample is taken until then.
// ----------------------------------------------------------------------------
module halfband_interpolator_by_two
    import hfi_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    hfi_in_if.sink    in_ch,
    hfi_out_if.source out_ch,
    hfi_cfg_if.sink   cfg
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [TAP_IDX_W-1:0] cnt_reg;
    logic [TAP_IDX_W-1:0] cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    sample_t              even_reg;
    sample_t              even_next;
    sample_t              odd_reg;
    sample_t              odd_next;
    coef_t                centre_reg;
    coef_t                centre_next;
    prod_t                odd_prod_reg;
    prod_t                odd_prod_next;

    logic       in_beat;
    logic       load_out;
    logic       mul_en;
    cell_ctrl_t cell_ctrl;
    acc_t       acc;
    sample_t    cell_sample [EVEN_TAPS];
    coef_t      cell_coef   [EVEN_TAPS];

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_beat     = in_ch.valid && in_ch.ready;
    assign cfg.ready   = 1'b1;
    assign mul_en      = (state_reg == ST_RUN);
    assign load_out    = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);

    assign cell_ctrl.shift  = in_beat;
    assign cell_ctrl.rotate = mul_en;

    // row of tap cells, ring closes from cell 0 back to the last cell
    for (genvar k = 0; k < EVEN_TAPS; k++)
    begin : g_cell
        localparam int NXT = (k + 1) % EVEN_TAPS;
        sample_t shift_src;
        logic    we;

        if (k == 0)
        begin : g_head
            assign shift_src = in_ch.sample_in;
        end
        else
        begin : g_body
            assign shift_src = cell_sample[k-1];
        end

        assign we = cfg.valid && (cfg.index == CFG_IDX_W'(k));

        hfi_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (cell_ctrl),
            .cfg_we       (we),
            .cfg_data     (cfg.data),
            .shift_sample (shift_src),
            .rot_sample   (cell_sample[NXT]),
            .rot_coef     (cell_coef[NXT]),
            .sample       (cell_sample[k]),
            .coef         (cell_coef[k])
        );
    end

    // even branch accumulator
    hfi_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (in_beat),
        .mul_en (mul_en),
        .coef   (cell_coef[0]),
        .sample (cell_sample[0]),
        .acc    (acc)
    );

    // sequencer, odd branch product and output register
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        even_next      = even_reg;
        odd_next       = odd_reg;
        centre_next    = centre_reg;
        odd_prod_next  = odd_prod_reg;

        if (cfg.valid && (cfg.index == CFG_CENTRE_COEF))
        begin
            centre_next = cfg.data;
        end

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                // ring is at home on the first pass cycle
                if (cnt_reg == '0)
                begin
                    odd_prod_next = centre_reg * cell_sample[ODD_DELAY];
                end
                if (cnt_reg == TAP_IDX_W'(EVEN_TAPS - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    even_next      = round_sat(acc);
                    odd_next       = round_sat(ACC_W'(odd_prod_reg));
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            even_reg      <= '0;
            odd_reg       <= '0;
            centre_reg    <= '0;
            odd_prod_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            even_reg      <= even_next;
            odd_reg       <= odd_next;
            centre_reg    <= centre_next;
            odd_prod_reg  <= odd_prod_next;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.even_out = even_reg;
    assign out_ch.odd_out  = odd_reg;

endmodule

[hdl/hfi_checker.sv]
// ----------------------------------------------------------------------------
// hfi_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module hfi_checker
    import hfi_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input sample_t even_out,
    input sample_t odd_out
);

    // a stalled result beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(even_out) && $stable(odd_out))
        else $error("result payload changed while stalled");

    // one sample in work at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second sample taken while one is in work");

    // a new result only appears at the end of a sample's pass
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while the block was idle");

endmodule

bind halfband_interpolator_by_two hfi_checker u_hfi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .even_out  (out_ch.even_out),
    .odd_out   (out_ch.odd_out)
);

[bench/halfband_interpolator_by_two_check.sv]
// ----------------------------------------------------------------------------
// halfband_interpolator_by_two_check
// Watches the sample, pair and register channels of the interpolator. It
// keeps its own copy of the taps and the sample history, works out the
// even and odd output pair for every sample beat, and compares each pair
// beat with the oldest pair still owed.
// ----------------------------------------------------------------------------
module halfband_interpolator_by_two_check
    import hfi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    hfi_in_if    in_ch,
    hfi_out_if   out_ch,
    hfi_cfg_if   cfg,
    output int   fails,
    output int   outstanding,
    output int   pairs_checked
);

    localparam int     NUM_EVEN_REGS = int'(CFG_CENTRE_COEF);
    localparam int     PRINT_LIMIT   = 40;
    localparam longint SAT_HI        = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAT_LO        = -SAT_HI - 1;
    localparam longint HALF_LSB      = longint'(1) <<< (FRAC_BITS - 1);

    typedef struct packed {
        sample_t even_out;
        sample_t odd_out;
    } pair_t;

    coef_t   even_taps [NUM_EVEN_REGS];
    coef_t   centre_tap;
    sample_t history [EVEN_TAPS-1];
    pair_t   owed_pairs [$];

    // one line per mismatch, printing capped
    task automatic report(input string msg);
        fails++;
        if (fails <= PRINT_LIMIT)
        begin
            $display("mismatch: %s", msg);
        end
    endtask

    // round half up, then clamp to the sample range
    function automatic sample_t round_to_sample(input longint acc);
        longint q;
        q = (acc + HALF_LSB) >>> FRAC_BITS;
        if (q > SAT_HI)
        begin
            q = SAT_HI;
        end
        else if (q < SAT_LO)
        begin
            q = SAT_LO;
        end
        return sample_t'(q);
    endfunction

    // expected pair for a new sample against the current history
    function automatic pair_t interpolate(input sample_t x);
        longint even_acc;
        longint odd_acc;
        pair_t  res;
        even_acc = longint'(even_taps[0]) * longint'(x);
        for (int k = 1; k < EVEN_TAPS; k++)
        begin
            even_acc += longint'(even_taps[k]) * longint'(history[k-1]);
        end
        if (ODD_DELAY == 0)
        begin
            odd_acc = longint'(centre_tap) * longint'(x);
        end
        else
        begin
            odd_acc = longint'(centre_tap) * longint'(history[ODD_DELAY-1]);
        end
        res.even_out = round_to_sample(even_acc);
        res.odd_out  = round_to_sample(odd_acc);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pair_t want;
        if (!rst_n)
        begin
            foreach (even_taps[k])
            begin
                even_taps[k] = '0;
            end
            foreach (history[k])
            begin
                history[k] = '0;
            end
            centre_tap = '0;
            owed_pairs.delete();
            fails = 0;
            pairs_checked = 0;
            outstanding <= 0;
        end
        else
        begin
            // register write beat, unknown indexes dropped
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index < CFG_CENTRE_COEF)
                begin
                    even_taps[cfg.index] = cfg.data;
                end
                else if (cfg.index == CFG_CENTRE_COEF)
                begin
                    centre_tap = cfg.data;
                end
            end

            // pair beat against the oldest owed pair
            if (out_ch.valid && out_ch.ready)
            begin
                if (owed_pairs.size() == 0)
                begin
                    report($sformatf("pair beat (%0d, %0d) with nothing owed",
                                     out_ch.even_out, out_ch.odd_out));
                end
                else
                begin
                    want = owed_pairs.pop_front();
                    if (out_ch.even_out !== want.even_out)
                    begin
                        report($sformatf("pair %0d even_out expected %0d, got %0d",
                                         pairs_checked, want.even_out, out_ch.even_out));
                    end
                    if (out_ch.odd_out !== want.odd_out)
                    begin
                        report($sformatf("pair %0d odd_out expected %0d, got %0d",
                                         pairs_checked, want.odd_out, out_ch.odd_out));
                    end
                    pairs_checked++;
                end
            end

            // sample beat: predict, then push into history
            if (in_ch.valid && in_ch.ready)
            begin
                owed_pairs.push_back(interpolate(in_ch.sample_in));
                for (int k = EVEN_TAPS - 2; k > 0; k--)
                begin
                    history[k] = history[k-1];
                end
                history[0] = in_ch.sample_in;
            end

            outstanding <= owed_pairs.size();
        end
    end

endmodule

[bench/halfband_interpolator_by_two_test.sv]
// ----------------------------------------------------------------------------
// halfband_interpolator_by_two_test
// Drives samples and tap writes into the interpolator with random gaps and
// output back-pressure, including one long output hold-off that fills the
// block. A checker beside the block predicts and compares every pair; this
// top only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module halfband_interpolator_by_two_test;
    import hfi_pkg::*;

    localparam int IDLE_PCT      = 21;
    localparam int HOLD_AT       = 500;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int PHASES        = 8;
    localparam int CALM_PHASE    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    localparam coef_t   COEF_MIN   = {1'b1, {(COEF_WIDTH-1){1'b0}}};
    localparam coef_t   COEF_MAX   = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    logic clk;
    logic rst_n;
    logic calm;
    int   sent_total;
    int   tap_sets;
    int   fails;
    int   outstanding;
    int   pairs_checked;

    coef_t tap_set [CFG_CENTRE_COEF+1];

    hfi_in_if  in_ch ();
    hfi_out_if out_ch ();
    hfi_cfg_if cfg_ch ();

    halfband_interpolator_by_two i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    halfband_interpolator_by_two_check i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .cfg           (cfg_ch),
        .fails         (fails),
        .outstanding   (outstanding),
        .pairs_checked (pairs_checked)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // one sample beat, with random idle cycles ahead of it
    task automatic send_sample(input sample_t s);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= s;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        sent_total++;
    endtask

    // stop offering and wait until every owed pair has come back
    task automatic end_burst();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    // one register write beat, valid left high
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input coef_t value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // write the whole tap set, optionally poking the unused index too
    task automatic load_taps(input bit with_spare);
        for (int i = 0; i <= int'(CFG_CENTRE_COEF); i++)
        begin
            cfg_write(CFG_IDX_W'(i), tap_set[i]);
        end
        if (with_spare)
        begin
            cfg_write(CFG_SPARE_IDX, coef_t'($urandom));
        end
        cfg_ch.valid <= 1'b0;
        tap_sets++;
    endtask

    function automatic coef_t pick_coef();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
        begin
            return COEF_MIN;
        end
        if (roll < 20)
        begin
            return COEF_MAX;
        end
        if (roll < 28)
        begin
            return '0;
        end
        if (roll < 60)
        begin
            return coef_t'(int'($urandom_range(8192)) - 4096);
        end
        return coef_t'($urandom);
    endfunction

    function automatic sample_t pick_sample();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 6)
        begin
            return SAMPLE_MIN;
        end
        if (roll < 12)
        begin
            return SAMPLE_MAX;
        end
        if (roll < 27)
        begin
            return sample_t'(int'($urandom_range(512)) - 256);
        end
        return sample_t'($urandom);
    endfunction

    // output side: random back-pressure plus one long hold-off
    initial
    begin : receiver
        int  hold_left;
        bit  held;
        hold_left    = 0;
        held         = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && sent_total >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (calm)
            begin
                out_ch.ready <= 1'b1;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // watchdog on cycles without any beat
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("timeout after %0d cycles without a beat", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // stimulus
    initial
    begin
        rst_n            = 1'b0;
        calm             = 1'b0;
        sent_total       = 0;
        tap_sets         = 0;
        in_ch.valid      = 1'b0;
        in_ch.sample_in  = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        repeat (3)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // taps still at their reset value
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        end_burst();

        // all taps at -1.0: both outputs saturate high on the most negative input
        foreach (tap_set[i])
        begin
            tap_set[i] = COEF_MIN;
        end
        load_taps(1'b0);
        repeat (6)
        begin
            send_sample(SAMPLE_MIN);
        end
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(sample_t'(1));
        send_sample(sample_t'(-1));
        send_sample('0);
        end_burst();

        // all taps at max positive, unused index poked: saturate low, then high
        foreach (tap_set[i])
        begin
            tap_set[i] = COEF_MAX;
        end
        load_taps(1'b1);
        repeat (6)
        begin
            send_sample(SAMPLE_MIN);
        end
        repeat (6)
        begin
            send_sample(SAMPLE_MAX);
        end
        end_burst();

        // random tap sets, each with a burst of random samples
        for (int p = 0; p < PHASES; p++)
        begin
            foreach (tap_set[i])
            begin
                tap_set[i] = pick_coef();
            end
            load_taps(p % 2 == 0);
            calm <= (p == CALM_PHASE);
            repeat (RANDOM_ITEMS / PHASES)
            begin
                send_sample(pick_sample());
            end
            end_burst();
        end

        // let any stray beat show up
        repeat (SETTLE_CYCLES)
        begin
            @(posedge clk);
        end

        $display("sent %0d samples under %0d tap settings, %0d pairs checked, %0d mismatches",
                 sent_total, tap_sets, pairs_checked, fails);
        $display("ran extreme taps and samples, saturation both ways, an unused index");
        if (fails == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
